[design/khbs_pkg.sv]
// ----------------------------------------------------------------------------
// khbs_pkg
// Shared types and constants for the key hash bucket select unit.
// ----------------------------------------------------------------------------
package khbs_pkg;

    localparam int HASH_W = 32;
    localparam int BKT_W  = 16;
    localparam int CNT_W  = $clog2(HASH_W + 1);

    localparam logic [HASH_W-1:0] HASH_SEED     = 32'd5381;
    localparam logic [HASH_W-1:0] HASH_MUL      = 32'h5bd1e995;
    localparam int                HASH_SHIFT    = 24;
    localparam int                FIN_SHIFT_A   = 13;
    localparam int                FIN_SHIFT_B   = 15;
    localparam logic [HASH_W-1:0] MAX_KEY_BYTES = 32'd65535;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

endpackage

[design/khbs_mod_unit.sv]
// ----------------------------------------------------------------------------
// khbs_mod_unit
// Restoring remainder unit: 32-bit hash modulo 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module khbs_mod_unit
    import khbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [HASH_W-1:0] dividend,
    input  logic [BKT_W-1:0]  divisor,
    output mod_stat_t        stat,
    output logic [BKT_W-1:0]  remainder
);

    logic [BKT_W-1:0]  rem_reg, rem_next;
    logic [HASH_W-1:0] dvd_reg, dvd_next;
    logic [BKT_W-1:0]  dsr_reg, dsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [BKT_W:0]    trial;
    logic [BKT_W:0]    diff;

    assign trial = {rem_reg, dvd_reg[HASH_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(HASH_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
                rem_next = diff[BKT_W-1:0];
            else
                rem_next = trial[BKT_W-1:0];
            dvd_next = {dvd_reg[HASH_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

[design/key_hash_bucket_select_unit.sv]
// ----------------------------------------------------------------------------
// key_hash_bucket_select_unit
// MurmurHash2 key hashing over little-endian words with bucket reduction.
// ----------------------------------------------------------------------------
// Takes one key word at a time. A four-byte word is accepted and then makes
// three passes through the single shared 32x32 multiplier, a short tail word
// makes one pass, and an empty word is only accepted. The last word of a key
// then adds one finalise pass through the multiplier, a start state for the
// remainder unit, 32 remainder steps at one hash bit per cycle and a wait for
// its done flag, then the output load. in_stall is high throughout, and the load also
// waits for as long as an earlier result word is held by out_stall; once
// loaded, the result sits in an output register and the next key may start
// while it waits.
// ----------------------------------------------------------------------------
module key_hash_bucket_select_unit
    import khbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [BKT_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [HASH_W-1:0] key_word,
    input  logic [2:0]        word_bytes,
    input  logic [15:0]       key_length,
    input  logic              last_word,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BKT_W-1:0]  bucket_index
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_BODY_K1   = 9'b000000010,
        S_BODY_K2   = 9'b000000100,
        S_BODY_H    = 9'b000001000,
        S_TAIL      = 9'b000010000,
        S_FIN       = 9'b000100000,
        S_MOD_START = 9'b001000000,
        S_MOD_WAIT  = 9'b010000000,
        S_OUT       = 9'b100000000
    } state_t;

    function automatic logic [HASH_W-1:0] tail_mask(input logic [1:0] n);
        logic [HASH_W-1:0] m;
        case (n)
            2'd1:    m = 32'h000000ff;
            2'd2:    m = 32'h0000ffff;
            2'd3:    m = 32'h00ffffff;
            default: m = '0;
        endcase
        return m;
    endfunction

    state_t            state_reg, state_next;
    logic [HASH_W-1:0] h_reg, h_next;
    logic [HASH_W-1:0] k_reg, k_next;
    logic [HASH_W-1:0] word_reg, word_next;
    logic [2:0]        nbytes_reg, nbytes_next;
    logic              last_reg, last_next;
    logic              first_reg, first_next;
    logic [BKT_W-1:0]  bc_reg, bc_next;
    logic              ov_reg, ov_next;
    logic [BKT_W-1:0]  bi_reg, bi_next;

    logic [HASH_W-1:0] mul_in;
    logic [HASH_W-1:0] prod;
    logic [HASH_W-1:0] seed;
    logic [HASH_W-1:0] klen;
    logic [HASH_W-1:0] fin_pre;
    logic [BKT_W-1:0]  divisor;
    logic              accept;
    logic              mod_start;
    mod_stat_t         mod_stat;
    logic [BKT_W-1:0]  mod_rem;

    assign accept  = in_valid && (state_reg == S_IDLE);
    assign klen    = ({16'd0, key_length} > MAX_KEY_BYTES) ? MAX_KEY_BYTES
                                                           : {16'd0, key_length};
    assign seed    = HASH_SEED ^ klen;
    assign fin_pre = h_reg ^ (h_reg >> FIN_SHIFT_A);
    assign divisor = (bc_reg == '0) ? BKT_W'(1) : bc_reg;

    always_comb
    begin
        case (state_reg)
            S_BODY_K1: mul_in = word_reg;
            S_BODY_K2: mul_in = k_reg ^ (k_reg >> HASH_SHIFT);
            S_BODY_H:  mul_in = h_reg;
            S_TAIL:    mul_in = h_reg ^ (word_reg & tail_mask(nbytes_reg[1:0]));
            S_FIN:     mul_in = fin_pre;
            default:   mul_in = h_reg;
        endcase
    end

    assign prod = mul_in * HASH_MUL;

    always_comb
    begin
        state_next  = state_reg;
        h_next      = h_reg;
        k_next      = k_reg;
        word_next   = word_reg;
        nbytes_next = nbytes_reg;
        last_next   = last_reg;
        first_next  = first_reg;
        bc_next     = cfg_we ? cfg_wdata : bc_reg;
        ov_next     = (ov_reg && !out_stall) ? 1'b0 : ov_reg;
        bi_next     = bi_reg;
        mod_start   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    word_next   = key_word;
                    nbytes_next = word_bytes;
                    last_next   = last_word;
                    if (first_reg)
                        h_next = seed;
                    if (word_bytes[2])
                        state_next = S_BODY_K1;
                    else if (word_bytes[1:0] != 2'd0)
                        state_next = S_TAIL;
                    else if (last_word)
                        state_next = S_FIN;
                    else
                        first_next = 1'b0;
                end
            end
            S_BODY_K1:
            begin
                k_next     = prod;
                state_next = S_BODY_K2;
            end
            S_BODY_K2:
            begin
                k_next     = prod;
                state_next = S_BODY_H;
            end
            S_BODY_H, S_TAIL:
            begin
                h_next = (state_reg == S_BODY_H) ? (prod ^ k_reg) : prod;
                if (last_reg)
                    state_next = S_FIN;
                else
                begin
                    first_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                h_next     = prod ^ (prod >> FIN_SHIFT_B);
                first_next = 1'b1;
                state_next = S_MOD_START;
            end
            S_MOD_START:
            begin
                mod_start  = 1'b1;
                state_next = S_MOD_WAIT;
            end
            S_MOD_WAIT:
            begin
                if (mod_stat.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    bi_next    = mod_rem;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    khbs_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (h_reg),
        .divisor   (divisor),
        .stat      (mod_stat),
        .remainder (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            h_reg     <= '0;
            first_reg <= 1'b1;
            bc_reg    <= BKT_W'(1);
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
            first_reg <= first_next;
            bc_reg    <= bc_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        word_reg   <= word_next;
        nbytes_reg <= nbytes_next;
        last_reg   <= last_next;
        bi_reg     <= bi_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = ov_reg;
    assign bucket_index = bi_reg;

endmodule

[design/khbs_checker.sv]
// ----------------------------------------------------------------------------
// khbs_checker
// Port-level checks for the key hash bucket select unit.
// ----------------------------------------------------------------------------
module khbs_checker
    import khbs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic [2:0]        word_bytes,
    input logic              last_word,
    input logic              out_valid,
    input logic              out_stall,
    input logic [BKT_W-1:0]  bucket_index
);

    // a word with bytes to mix, or a closing word, keeps the block busy
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (last_word || word_bytes != 3'd0)) |=> in_stall)
        else $error("block not busy after accepting a working word");

    // a result only appears out of a busy period
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a busy period");

    // a new result cannot be loaded in the same cycle the block starts a word
    a_no_accept_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !$rose(out_valid))
        else $error("result loaded straight after an accepted word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(bucket_index)))
        else $error("stalled result word changed");

endmodule

bind key_hash_bucket_select_unit khbs_checker u_khbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .word_bytes   (word_bytes),
    .last_word    (last_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bucket_index (bucket_index)
);

[tb/sv/key_hash_bucket_select_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_hash_bucket_select_unit_tb
// Self-checking bench for the key hash bucket select unit.
// Streams keys as little-endian words under random sender gaps and receiver
// stalls. A behavioural hash model predicts each bucket index, which is
// compared in order with the block's output words. The bucket count is changed
// between idle phases.
// ----------------------------------------------------------------------------
module key_hash_bucket_select_unit_tb
    import khbs_pkg::*;
();

    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 62;

    class khbs_bucket_predictor;
        logic [HASH_W-1:0] hash_acc;
        bit                first_word;
        logic [BKT_W-1:0]  bucket_count;
        logic [BKT_W-1:0]  expected_buckets[$];
        int                words_seen;
        int                keys_seen;
        int                failures;

        function new();
            hash_acc     = '0;
            first_word   = 1'b1;
            bucket_count = 16'd1;
            words_seen   = 0;
            keys_seen    = 0;
            failures     = 0;
        endfunction

        function void note_word(logic [HASH_W-1:0] w, logic [2:0] nb,
                                logic [15:0] klen, logic lw);
            logic [HASH_W-1:0] h;
            logic [HASH_W-1:0] k;
            logic [HASH_W-1:0] mask;
            logic [HASH_W-1:0] div;
            words_seen++;
            if (first_word)
                hash_acc = HASH_SEED ^ (({16'd0, klen} > MAX_KEY_BYTES) ?
                                        MAX_KEY_BYTES : {16'd0, klen});
            h = hash_acc;
            if (nb >= 3'd4)
            begin
                k = w * HASH_MUL;
                k = k ^ (k >> HASH_SHIFT);
                k = k * HASH_MUL;
                h = (h * HASH_MUL) ^ k;
            end
            else if (nb != 3'd0)
            begin
                mask = ~({HASH_W{1'b1}} << (8 * nb));
                h = (h ^ (w & mask)) * HASH_MUL;
            end
            if (!lw)
            begin
                hash_acc   = h;
                first_word = 1'b0;
                return;
            end
            h = h ^ (h >> FIN_SHIFT_A);
            h = h * HASH_MUL;
            h = h ^ (h >> FIN_SHIFT_B);
            hash_acc   = h;
            first_word = 1'b1;
            div = (bucket_count == '0) ? 32'd1 : {16'd0, bucket_count};
            expected_buckets.push_back(BKT_W'(h % div));
            keys_seen++;
        endfunction

        function void check_bucket(logic [BKT_W-1:0] got);
            logic [BKT_W-1:0] want;
            if (expected_buckets.size() == 0)
            begin
                $error("bucket_index: expected none, actual %0d", got);
                failures++;
            end
            else
            begin
                want = expected_buckets.pop_front();
                if (got !== want)
                begin
                    $error("bucket_index: expected %0d, actual %0d", want, got);
                    failures++;
                end
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              cfg_we       = 1'b0;
    logic [BKT_W-1:0]  cfg_wdata    = '0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [HASH_W-1:0] key_word     = '0;
    logic [2:0]        word_bytes   = '0;
    logic [15:0]       key_length   = '0;
    logic              last_word    = 1'b0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [BKT_W-1:0]  bucket_index;

    khbs_bucket_predictor hash_model = new();

    int stall_mode   = 0;
    int stall_run    = 0;
    bit gap_on       = 1'b0;
    int burst_left   = 0;
    int quiet_cycles = 0;
    int settings_run = 1;

    key_hash_bucket_select_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .key_word     (key_word),
        .word_bytes   (word_bytes),
        .key_length   (key_length),
        .last_word    (last_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bucket_index (bucket_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (stall_run > 0)
            stall_run <= stall_run - 1;
        else
        begin
            case (stall_mode)
                1:
                begin
                    out_stall <= 1'($urandom_range(0, 1));
                    stall_run <= $urandom_range(0, 3);
                end
                2:
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        out_stall <= 1'b1;
                        stall_run <= $urandom_range(5, 40);
                    end
                    else
                    begin
                        out_stall <= 1'b0;
                        stall_run <= $urandom_range(0, 12);
                    end
                end
                default:
                begin
                    out_stall <= 1'b0;
                    stall_run <= 0;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                hash_model.check_bucket(bucket_index);
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_we)
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [HASH_W-1:0] w, input logic [2:0] nb,
                             input logic [15:0] klen, input logic lw);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (gap_on)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        key_word   <= w;
        word_bytes <= nb;
        key_length <= klen;
        last_word  <= lw;
        do @(posedge clk); while (in_stall);
        hash_model.note_word(w, nb, klen, lw);
    endtask

    // fill: 0 random, 1 all zeros, 2 all ones; later words carry junk lengths
    task automatic send_key(input int nbytes, input logic [15:0] klen, input int fill);
        int                left;
        bit                first;
        logic [HASH_W-1:0] w;
        left  = nbytes;
        first = 1'b1;
        while (left > 4)
        begin
            w = (fill == 1) ? '0 : (fill == 2) ? '1 : HASH_W'($urandom);
            send_word(w, 3'd4, first ? klen : 16'($urandom), 1'b0);
            first = 1'b0;
            left -= 4;
        end
        w = (fill == 1) ? '0 : (fill == 2) ? '1 : HASH_W'($urandom);
        send_word(w, 3'(left), first ? klen : 16'($urandom), 1'b1);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (hash_model.expected_buckets.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_buckets(input logic [BKT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        hash_model.bucket_count = value;
        settings_run++;
    endtask

    task automatic run_phase(input int word_target);
        int r;
        int n;
        while (hash_model.words_seen < word_target)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                // malformed key: any byte count, junk lengths
                n = $urandom_range(1, 4);
                repeat (n - 1)
                    send_word($urandom, 3'($urandom_range(0, 7)), 16'($urandom), 1'b0);
                send_word($urandom, 3'($urandom_range(0, 7)), 16'($urandom), 1'b1);
            end
            else
            begin
                n = (r < 85) ? $urandom_range(0, 16) : $urandom_range(17, 64);
                send_key(n, ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(n), 0);
            end
        end
        settle();
    endtask

    initial
    begin
        logic [BKT_W-1:0] bucket_plan[8];
        bucket_plan = '{16'd0, 16'd2, 16'd65534, 16'd3, BKT_W'($urandom_range(4, 65533)),
                        16'd1, 16'd1000, BKT_W'($urandom_range(1, 255))};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset bucket count
        run_phase(20);

        write_buckets(16'd65535);
        stall_mode = 1;
        gap_on     = 1'b1;
        send_key(0, 16'd0, 0);
        send_key(0, 16'hffff, 0);
        send_key(1, 16'd1, 2);
        send_key(2, 16'd2, 1);
        send_key(3, 16'd3, 2);
        send_key(4, 16'd4, 2);
        send_key(4, 16'd4, 1);
        send_key(7, 16'd7, 0);
        send_key(8, 16'd8, 2);
        send_key(5, 16'd1000, 0);
        send_word($urandom, 3'd7, 16'd4, 1'b1);
        send_word($urandom, 3'd5, 16'd8, 1'b0);
        send_word($urandom, 3'd6, 16'hffff, 1'b1);
        // short word mid-key
        send_word($urandom, 3'd2, 16'd6, 1'b0);
        send_word($urandom, 3'd4, 16'd0, 1'b1);
        settle();

        foreach (bucket_plan[i])
        begin
            write_buckets(bucket_plan[i]);
            stall_mode = i % 3;
            gap_on     = (i % 4) != 1;
            run_phase(hash_model.words_seen + PHASE_WORDS);
        end

        $display("Hashed %0d keys from %0d words under %0d bucket counts,",
                 hash_model.keys_seen, hash_model.words_seen, settings_run);
        $display("including counts 0, 1, 65534 and 65535, with gaps and stalls varied.");
        if (hash_model.failures == 0 && hash_model.expected_buckets.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
design/khbs_pkg.sv
design/khbs_mod_unit.sv
design/key_hash_bucket_select_unit.sv
design/khbs_checker.sv
tb/sv/key_hash_bucket_select_unit_tb.sv
